// ===== rtl/core/smc_pkg.sv =====
// shared types and constants of the in-place cross smoother
`timescale 1ns / 1ps
package smc_pkg;

   localparam int ROW_LENGTH_DEF = 200;
   localparam int MAP_CELLS_DEF  = 40000;

   localparam int HEIGHT_W  = 8;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_START = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_END   = 1'b1;

   localparam logic [CFG_W-1:0] FILTER_START_RST = 16'd200;
   localparam logic [CFG_W-1:0] FILTER_END_RST   = 16'd38800;

   // five bytes summed, then floor division by five through a reciprocal
   localparam int SUM_W      = 11;
   localparam int DIV5_SHIFT = 13;
   localparam logic [SUM_W-1:0] DIV5_MUL = 11'd1639;

   typedef struct packed {
      logic raw_shift;
      logic smooth_shift;
   } cell_ctl_type;

endpackage

// ===== rtl/core/smc_req_if.sv =====
// input beat channel: mode and raw height
`timescale 1ns / 1ps
interface smc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [smc_pkg::HEIGHT_W-1:0]  height;

   modport source (output valid, mode, height, input ready);
   modport sink   (input valid, mode, height, output ready);
endinterface

// ===== rtl/core/smc_rsp_if.sv =====
// result beat channel: final height and end of frame flag
`timescale 1ns / 1ps
interface smc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [smc_pkg::HEIGHT_W-1:0]  smoothed;
   logic                          last;

   modport source (output valid, smoothed, last, input ready);
   modport sink   (input valid, smoothed, last, output ready);
endinterface

// ===== rtl/core/smc_csr_if.sv =====
// register write channel
`timescale 1ns / 1ps
interface smc_csr_if;
   logic                           valid;
   logic                           ready;
   logic [smc_pkg::CSR_IDX_W-1:0]  index;
   logic [smc_pkg::CFG_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/smc_cell.sv =====
// one window cell: a raw byte and a final byte, each shifting to the next cell
`timescale 1ns / 1ps
module smc_cell (
   input  logic                          clock,
   input  smc_pkg::cell_ctl_type         ctl,
   input  logic [smc_pkg::HEIGHT_W-1:0]  raw_prev,
   input  logic [smc_pkg::HEIGHT_W-1:0]  smooth_prev,
   output logic [smc_pkg::HEIGHT_W-1:0]  raw_ff,
   output logic [smc_pkg::HEIGHT_W-1:0]  smooth_ff
);

   always_ff @(posedge clock) begin
      if (ctl.raw_shift) begin
         raw_ff <= raw_prev;
      end
      if (ctl.smooth_shift) begin
         smooth_ff <= smooth_prev;
      end
   end

endmodule

// ===== rtl/core/smc_chain.sv =====
// row of window cells holding the last row of raw and final heights
`timescale 1ns / 1ps
module smc_chain #(
   parameter int ROW_LENGTH = smc_pkg::ROW_LENGTH_DEF
) (
   input  logic                          clock,
   input  smc_pkg::cell_ctl_type         ctl,
   input  logic [smc_pkg::HEIGHT_W-1:0]  raw_in,
   input  logic [smc_pkg::HEIGHT_W-1:0]  smooth_in,
   output logic [smc_pkg::HEIGHT_W-1:0]  raw_own,
   output logic [smc_pkg::HEIGHT_W-1:0]  raw_right,
   output logic [smc_pkg::HEIGHT_W-1:0]  smooth_left,
   output logic [smc_pkg::HEIGHT_W-1:0]  smooth_up
);

   logic [smc_pkg::HEIGHT_W-1:0] raw_tap    [ROW_LENGTH+1];
   logic [smc_pkg::HEIGHT_W-1:0] smooth_tap [ROW_LENGTH+1];

   assign raw_tap[0]    = raw_in;
   assign smooth_tap[0] = smooth_in;

   for (genvar k = 0; k < ROW_LENGTH; k++) begin : g_cell
      smc_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .raw_prev    (raw_tap[k]),
         .smooth_prev (smooth_tap[k]),
         .raw_ff      (raw_tap[k+1]),
         .smooth_ff   (smooth_tap[k+1])
      );
   end

   // newest entry sits in the first cell, oldest in the last
   assign raw_own     = raw_tap[ROW_LENGTH];
   assign raw_right   = raw_tap[ROW_LENGTH-1];
   assign smooth_left = smooth_tap[1];
   assign smooth_up   = smooth_tap[ROW_LENGTH];

endmodule

// ===== rtl/core/smc_avg.sv =====
// five point sum and floor division by five
`timescale 1ns / 1ps
module smc_avg (
   input  logic [smc_pkg::HEIGHT_W-1:0]  left,
   input  logic [smc_pkg::HEIGHT_W-1:0]  up,
   input  logic [smc_pkg::HEIGHT_W-1:0]  own,
   input  logic [smc_pkg::HEIGHT_W-1:0]  right,
   input  logic [smc_pkg::HEIGHT_W-1:0]  down,
   output logic [smc_pkg::HEIGHT_W-1:0]  mean
);

   localparam int PROD_W = 2 * smc_pkg::SUM_W;

   logic [smc_pkg::SUM_W-1:0] sum;
   logic [PROD_W-1:0]         prod;

   assign sum = smc_pkg::SUM_W'(left) + smc_pkg::SUM_W'(up) + smc_pkg::SUM_W'(own)
              + smc_pkg::SUM_W'(right) + smc_pkg::SUM_W'(down);

   // exact for every sum up to five full bytes
   assign prod = PROD_W'(sum) * PROD_W'(smc_pkg::DIV5_MUL);
   assign mean = prod[smc_pkg::DIV5_SHIFT +: smc_pkg::HEIGHT_W];

endmodule

// ===== rtl/core/in_place_cross_smoother_core.sv =====
// top level of the in-place cross smoother
`timescale 1ns / 1ps
// takes one beat per cycle unless the output holds an unaccepted result or the window is being aligned;
// cell i is finished when raw cell i+row arrives or when drained; a result sits in the output register
// in the cycle after the beat that finishes its cell; a drain of a frame shorter than one row first stalls
// the input while zeros shift into the window until it is full, so the oldest cell lines up with the cell to finish
// reset clears counters, fill count, drain flag and output valid, loads the default range
module in_place_cross_smoother_core #(
   parameter int ROW_LENGTH = smc_pkg::ROW_LENGTH_DEF,
   parameter int MAP_CELLS  = smc_pkg::MAP_CELLS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   smc_req_if.sink       req_ch,
   smc_rsp_if.source     rsp_ch,
   smc_csr_if.sink       csr_ch
);

   localparam int CNT_W  = $clog2(MAP_CELLS + 1);
   localparam int FILL_W = $clog2(ROW_LENGTH + 1);
   localparam int CMP_W  = (CNT_W > smc_pkg::CFG_W) ? CNT_W : smc_pkg::CFG_W;
   localparam int HW     = smc_pkg::HEIGHT_W;

   logic [smc_pkg::CFG_W-1:0] filter_start_ff, filter_start_in;
   logic [smc_pkg::CFG_W-1:0] filter_end_ff, filter_end_in;
   logic [CNT_W-1:0]          cells_in_ff, cells_in_in;
   logic [CNT_W-1:0]          cells_out_ff, cells_out_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic                      draining_ff, draining_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [HW-1:0]             rsp_smoothed_ff;
   logic                      rsp_last_ff;

   logic          full, need_align, align_step, out_ok, req_acc;
   logic          pix_take, pix_fin, drn_fin, fin, last_cell, in_range;
   logic [HW-1:0] raw_own, raw_right, smooth_left, smooth_up;
   logic [HW-1:0] left, up, down, mean, value;
   logic [CMP_W-1:0] idx_ext, start_ext, end_ext;
   smc_pkg::cell_ctl_type ctl;

   // register writes
   assign csr_ch.ready = 1'b1;

   always_comb begin
      filter_start_in = filter_start_ff;
      filter_end_in   = filter_end_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            smc_pkg::CSR_FILTER_START: filter_start_in = csr_ch.data;
            smc_pkg::CSR_FILTER_END:   filter_end_in   = csr_ch.data;
            default: ;
         endcase
      end
   end

   // handshake and beat decode
   assign full       = (fill_ff == FILL_W'(ROW_LENGTH));
   assign need_align = !full && (cells_in_ff != '0);
   assign align_step = req_ch.valid && req_ch.mode && need_align;
   assign out_ok     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = out_ok && !align_step;
   assign req_acc    = req_ch.valid && req_ch.ready;

   assign pix_take  = req_acc && !req_ch.mode && !draining_ff
                    && (cells_in_ff != CNT_W'(MAP_CELLS));
   assign pix_fin   = pix_take && full;
   assign drn_fin   = req_acc && req_ch.mode && (cells_out_ff != cells_in_ff);
   assign fin       = pix_fin || drn_fin;
   assign last_cell = ((cells_out_ff + CNT_W'(1)) == cells_in_ff);

   // neighbors of the cell being finished
   assign left = (cells_out_ff != '0) ? smooth_left : '0;
   assign up   = (cells_out_ff >= CNT_W'(ROW_LENGTH)) ? smooth_up : '0;
   assign down = req_ch.mode ? '0 : req_ch.height;

   assign idx_ext   = CMP_W'(cells_out_ff);
   assign start_ext = CMP_W'(filter_start_ff);
   assign end_ext   = CMP_W'(filter_end_ff);
   assign in_range  = (idx_ext >= start_ext) && (idx_ext < end_ext);
   assign value     = in_range ? mean : raw_own;

   assign ctl.raw_shift    = pix_take || drn_fin || align_step;
   assign ctl.smooth_shift = fin;

   smc_chain #(
      .ROW_LENGTH (ROW_LENGTH)
   ) u_chain (
      .clock       (clock),
      .ctl         (ctl),
      .raw_in      (down),
      .smooth_in   (value),
      .raw_own     (raw_own),
      .raw_right   (raw_right),
      .smooth_left (smooth_left),
      .smooth_up   (smooth_up)
   );

   smc_avg u_avg (
      .left  (left),
      .up    (up),
      .own   (raw_own),
      .right (raw_right),
      .down  (down),
      .mean  (mean)
   );

   // frame counters
   always_comb begin
      cells_in_in  = cells_in_ff;
      cells_out_in = cells_out_ff;
      fill_in      = fill_ff;
      draining_in  = draining_ff;
      if (pix_take) begin
         cells_in_in = cells_in_ff + CNT_W'(1);
      end
      if (pix_fin) begin
         cells_out_in = cells_out_ff + CNT_W'(1);
      end
      if (!full && (pix_take || align_step)) begin
         fill_in = fill_ff + FILL_W'(1);
      end
      if (drn_fin) begin
         if (last_cell) begin
            cells_in_in  = '0;
            cells_out_in = '0;
            fill_in      = '0;
            draining_in  = 1'b0;
         end else begin
            cells_out_in = cells_out_ff + CNT_W'(1);
            draining_in  = 1'b1;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fin) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_start_ff <= smc_pkg::FILTER_START_RST;
         filter_end_ff   <= smc_pkg::FILTER_END_RST;
         cells_in_ff     <= '0;
         cells_out_ff    <= '0;
         fill_ff         <= '0;
         draining_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         filter_start_ff <= filter_start_in;
         filter_end_ff   <= filter_end_in;
         cells_in_ff     <= cells_in_in;
         cells_out_ff    <= cells_out_in;
         fill_ff         <= fill_in;
         draining_ff     <= draining_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin) begin
         rsp_smoothed_ff <= value;
         rsp_last_ff     <= drn_fin && last_cell;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.smoothed = rsp_smoothed_ff;
   assign rsp_ch.last     = rsp_last_ff;

   // checks
   assert property (@(posedge clock) disable iff (reset)
      cells_out_ff <= cells_in_ff)
      else $error("more cells finished than received");

   assert property (@(posedge clock) disable iff (reset)
      (!draining_ff && cells_in_ff >= CNT_W'(ROW_LENGTH))
      |-> (cells_out_ff == cells_in_ff - CNT_W'(ROW_LENGTH)))
      else $error("finish index lost its one row lag");

   assert property (@(posedge clock) disable iff (reset)
      draining_ff |-> full)
      else $error("drain running on an unaligned window");

   assert property (@(posedge clock) disable iff (reset)
      (cells_in_ff >= CNT_W'(ROW_LENGTH)) |-> full)
      else $error("window fill count behind received cells");

   assert property (@(posedge clock) disable iff (reset)
      (drn_fin && last_cell) |=> (cells_in_ff == '0 && !draining_ff && rsp_ch.last))
      else $error("frame end beat did not restart the frame");

endmodule
